// ===== design/ami_pkg.sv =====
// Shared types, defaults and the adjugate operand table for the affine inverse.
// Used by ami_div, the top level and the testbench; no dependencies.
package ami_pkg;

    localparam int ENTRY_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int FIELD_W         = 32;

    typedef struct packed {
        logic signed [FIELD_W-1:0] entry_c0;
        logic signed [FIELD_W-1:0] entry_c1;
        logic signed [FIELD_W-1:0] entry_c2;
        logic signed [FIELD_W-1:0] entry_c3;
    } src_item_t;

    typedef struct packed {
        logic [1:0]                row_index;
        logic signed [FIELD_W-1:0] inv_c0;
        logic signed [FIELD_W-1:0] inv_c1;
        logic signed [FIELD_W-1:0] inv_c2;
        logic signed [FIELD_W-1:0] inv_c3;
        logic                      status;
        logic                      saturated;
        logic                      last;
    } res_item_t;

    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

    // Store index (row*4+col) of the operands p, q, r, s of adjugate entry k,
    // where the entry is p*q - r*s before the cofactor sign.
    function automatic logic [3:0] adj_src(input logic [3:0] k, input logic [1:0] pos);
        logic [15:0] ops;
        logic [3:0]  sel;
        case (k)
            4'd0:    ops = {4'd5, 4'd10, 4'd9, 4'd6};
            4'd1:    ops = {4'd1, 4'd10, 4'd9, 4'd2};
            4'd2:    ops = {4'd1, 4'd6,  4'd5, 4'd2};
            4'd3:    ops = {4'd4, 4'd10, 4'd8, 4'd6};
            4'd4:    ops = {4'd0, 4'd10, 4'd8, 4'd2};
            4'd5:    ops = {4'd0, 4'd6,  4'd4, 4'd2};
            4'd6:    ops = {4'd4, 4'd9,  4'd8, 4'd5};
            4'd7:    ops = {4'd0, 4'd9,  4'd8, 4'd1};
            4'd8:    ops = {4'd0, 4'd5,  4'd4, 4'd1};
            default: ops = '0;
        endcase
        case (pos)
            2'd0:    sel = ops[15:12];
            2'd1:    sel = ops[11:8];
            2'd2:    sel = ops[7:4];
            default: sel = ops[3:0];
        endcase
        return sel;
    endfunction

    // Cofactor sign: the odd positions of the 3x3 adjugate are negated.
    function automatic logic adj_flip(input logic [3:0] k);
        return k inside {4'd1, 4'd3, 4'd5, 4'd7};
    endfunction

endpackage

// ===== design/ami_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on nothing but its parameter; instantiated by the top level.
module ami_mul #(
    parameter int ENTRY_WIDTH = 32
) (
    input  logic                            clk,
    input  logic signed [ENTRY_WIDTH:0]     a,
    input  logic signed [ENTRY_WIDTH:0]     b,
    output logic signed [2*ENTRY_WIDTH+1:0] p
);

    always_ff @(posedge clk)
    begin
        p <= a * b;
    end

endmodule

// ===== design/ami_div.sv =====
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit a cycle.
// Depends on ami_pkg for the control and status structs.
module ami_div #(
    parameter int NUM_W = 97,
    parameter int DEN_W = 98
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ami_pkg::div_ctl_t    ctl,
    input  logic [NUM_W-1:0]     num,
    input  logic [DEN_W-1:0]     den,
    output ami_pkg::div_sts_t    sts,
    output logic [NUM_W-1:0]     quo
);
    import ami_pkg::*;

    localparam int REM_W = DEN_W + 1;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [REM_W-1:0] rem_reg;
    logic [NUM_W-1:0] nsh_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W:0]   diff;
    logic             ge;
    logic [REM_W-1:0] rem_next;

    // The numerator shifts out at the top while quotient bits shift in below.
    assign rem_sh   = {rem_reg[REM_W-2:0], nsh_reg[NUM_W-1]};
    assign diff     = {1'b0, rem_sh} - {2'b00, den};
    assign ge       = ~diff[REM_W];
    assign rem_next = ge ? diff[REM_W-1:0] : rem_sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start && !busy_reg)
        begin
            rem_reg <= '0;
            nsh_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            nsh_reg <= {nsh_reg[NUM_W-2:0], ge};
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quo      = nsh_reg;

endmodule

// ===== design/affine_matrix_inverse_3x4.sv =====
// Top level of the 3x4 affine matrix inverse: sequencer, operand store and accumulator.
// Depends on ami_pkg, ami_mul and ami_div.
//
//   channel | signals                     | moves
//   src     | src_valid src_stall src_data | one source row per transfer
//   res     | res_valid res_stall res_data | one inverse row (or singular flag)
//
// The first two rows are only stored. The third row starts the inversion:
// 18 adjugate products and 6 determinant partial products on the shared
// multiplier, then, for each of the three rows, three quotients on the bit-serial
// divider (nine in all) followed by the translation products of that row.
// Reset clears the sequencer and the row count; the store needs no clearing.
// src_stall is high from the third row until the last result transfer; each
// result waits in the output register until res_stall is low.
module affine_matrix_inverse_3x4 #(
    parameter int ENTRY_WIDTH = ami_pkg::ENTRY_WIDTH_DEF,
    parameter int FRAC_BITS   = ami_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_stall,
    input  ami_pkg::src_item_t src_data,
    output logic               res_valid,
    input  logic               res_stall,
    output ami_pkg::res_item_t res_data
);
    import ami_pkg::*;

    localparam int W     = ENTRY_WIDTH;
    localparam int OP_W  = W + 1;
    localparam int PR_W  = 2 * W + 2;
    localparam int ADJ_W = 2 * W + 1;
    localparam int ACC_W = 3 * W + 2;
    localparam int NUM_W = ADJ_W + 2 * FRAC_BITS;
    localparam int TR_W  = 2 * W + 2;

    localparam logic [NUM_W-1:0] QLIM_P = NUM_W'((64'd1 << (W - 1)) - 64'd1);
    localparam logic [NUM_W-1:0] QLIM_N = NUM_W'(64'd1 << (W - 1));
    localparam logic [TR_W-1:0]  TLIM_P = TR_W'((64'd1 << (W - 1)) - 64'd1);
    localparam logic [TR_W-1:0]  TLIM_N = TR_W'(64'd1 << (W - 1));
    localparam logic signed [W-1:0] MAXV = W'((64'd1 << (W - 1)) - 64'd1);
    localparam logic signed [W-1:0] MINV = {1'b1, {(W - 1){1'b0}}};

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_ADJ  = 7'b0000010,
        ST_DET  = 7'b0000100,
        ST_CHK  = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_TRN  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t                  state_reg;
    logic [1:0]              row_count_reg;
    logic signed [W-1:0]     store_reg [12];
    logic signed [ADJ_W-1:0] adj_reg [9];
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [OP_W-1:0]  opa_reg;
    logic signed [OP_W-1:0]  opb_reg;
    logic [1:0]              ph_reg;
    logic [2:0]              sub_reg;
    logic [3:0]              k_reg;
    logic [1:0]              row_reg;
    logic [1:0]              col_reg;
    logic                    detneg_reg;
    logic [ACC_W-1:0]        den_reg;
    logic                    qneg_reg;
    logic signed [W-1:0]     inv_reg [3];
    logic                    sat_reg;
    logic                    res_valid_reg;
    res_item_t               res_reg;

    logic [3:0]              rd_idx;
    logic signed [W-1:0]     rd_val;
    logic [3:0]              adj_idx;
    logic signed [ADJ_W-1:0] adj_val;
    logic [ADJ_W-1:0]        adj_mag;
    logic signed [PR_W-1:0]  prod;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ADJ_W-1:0] adj_new;
    div_ctl_t                div_ctl;
    div_sts_t                div_sts;
    logic [NUM_W-1:0]        quo;
    logic                    q_over;
    logic signed [W-1:0]     q_val;
    logic signed [TR_W-1:0]  acc_tr;
    logic [TR_W-1:0]         tr_mag;
    logic [TR_W-1:0]         tr_sh;
    logic                    tr_neg;
    logic                    tr_over;
    logic signed [W-1:0]     tr_val;
    logic                    src_take;
    logic                    res_take;

    assign src_take = src_valid && !src_stall;
    assign res_take = res_valid_reg && !res_stall;

    // Operand selection for the single store read port and the adjugate read port.
    always_comb
    begin
        case (state_reg)
            ST_ADJ:  rd_idx = adj_src(k_reg, {sub_reg[0], ph_reg[0]});
            ST_DET:  rd_idx = {2'b00, sub_reg[2:1]};
            ST_TRN:  rd_idx = {sub_reg[1:0], 2'b11};
            default: rd_idx = '0;
        endcase
        case (state_reg)
            ST_DET:  adj_idx = 4'({2'b00, sub_reg[2:1]} * 4'd3);
            default: adj_idx = 4'({2'b00, row_reg} * 4'd3) + {2'b00, col_reg};
        endcase
    end

    assign rd_val  = store_reg[rd_idx];
    assign adj_val = adj_reg[adj_idx];
    assign adj_mag = adj_val[ADJ_W-1] ? ADJ_W'(-adj_val) : adj_val;

    ami_mul #(.ENTRY_WIDTH(W)) u_mul (
        .clk (clk),
        .a   (opa_reg),
        .b   (opb_reg),
        .p   (prod)
    );

    assign div_ctl.start = (state_reg == ST_DIV) && (ph_reg == 2'd0) && !div_sts.busy;

    ami_div #(.NUM_W(NUM_W), .DEN_W(ACC_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .num   ({adj_mag, {(2 * FRAC_BITS){1'b0}}}),
        .den   (den_reg),
        .sts   (div_sts),
        .quo   (quo)
    );

    // Accumulation; in the determinant the high half of an adjugate entry
    // carries a weight of two to the entry width.
    always_comb
    begin
        prod_ext = ACC_W'(prod);
        case (state_reg)
            ST_ADJ:  acc_next = sub_reg[0] ? acc_reg - prod_ext : prod_ext;
            ST_DET:  acc_next = acc_reg + (sub_reg[0] ? (prod_ext <<< W) : prod_ext);
            default: acc_next = acc_reg + prod_ext;
        endcase
        adj_new = adj_flip(k_reg) ? ADJ_W'(-acc_next) : ADJ_W'(acc_next);
    end

    // Quotient saturation.
    always_comb
    begin
        if (qneg_reg)
        begin
            q_over = quo > QLIM_N;
            q_val  = q_over ? MINV : W'(-quo[W-1:0]);
        end
        else
        begin
            q_over = quo > QLIM_P;
            q_val  = q_over ? MAXV : quo[W-1:0];
        end
    end

    // Translation: minus the sum, truncated toward zero and saturated.
    always_comb
    begin
        acc_tr = acc_next[TR_W-1:0];
        tr_neg = !acc_tr[TR_W-1] && (acc_tr != '0);
        tr_mag = acc_tr[TR_W-1] ? TR_W'(-acc_tr) : acc_tr;
        tr_sh  = tr_mag >> FRAC_BITS;
        if (tr_neg)
        begin
            tr_over = tr_sh > TLIM_N;
            tr_val  = tr_over ? MINV : W'(-tr_sh[W-1:0]);
        end
        else
        begin
            tr_over = tr_sh > TLIM_P;
            tr_val  = tr_over ? MAXV : tr_sh[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_count_reg <= '0;
            ph_reg        <= '0;
            sub_reg       <= '0;
            k_reg         <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (src_take)
                    begin
                        if (row_count_reg == 2'd2)
                        begin
                            row_count_reg <= '0;
                            state_reg     <= ST_ADJ;
                            ph_reg        <= '0;
                            sub_reg       <= '0;
                            k_reg         <= '0;
                        end
                        else
                        begin
                            row_count_reg <= row_count_reg + 1'b1;
                        end
                    end
                end
                ST_ADJ:
                begin
                    ph_reg <= ph_reg + 1'b1;
                    if (ph_reg == 2'd3)
                    begin
                        if (sub_reg[0])
                        begin
                            sub_reg <= '0;
                            if (k_reg == 4'd8)
                            begin
                                state_reg <= ST_DET;
                            end
                            else
                            begin
                                k_reg <= k_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            sub_reg <= 3'd1;
                        end
                    end
                end
                ST_DET:
                begin
                    ph_reg <= ph_reg + 1'b1;
                    if (ph_reg == 2'd3)
                    begin
                        if (sub_reg == 3'd5)
                        begin
                            state_reg <= ST_CHK;
                        end
                        else
                        begin
                            sub_reg <= sub_reg + 1'b1;
                        end
                    end
                end
                ST_CHK:
                begin
                    row_reg <= '0;
                    col_reg <= '0;
                    ph_reg  <= '0;
                    if (acc_reg == '0)
                    begin
                        state_reg     <= ST_OUT;
                        res_valid_reg <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (ph_reg == 2'd0)
                    begin
                        if (!div_sts.busy)
                        begin
                            ph_reg <= 2'd1;
                        end
                    end
                    else if (div_sts.done)
                    begin
                        ph_reg <= '0;
                        if (col_reg == 2'd2)
                        begin
                            state_reg <= ST_TRN;
                            sub_reg   <= '0;
                        end
                        else
                        begin
                            col_reg <= col_reg + 1'b1;
                        end
                    end
                end
                ST_TRN:
                begin
                    ph_reg <= ph_reg + 1'b1;
                    if (ph_reg == 2'd3)
                    begin
                        if (sub_reg == 3'd2)
                        begin
                            state_reg     <= ST_OUT;
                            res_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            sub_reg <= sub_reg + 1'b1;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (res_take)
                    begin
                        res_valid_reg <= 1'b0;
                        if (res_reg.last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_DIV;
                            row_reg   <= row_reg + 1'b1;
                            col_reg   <= '0;
                            ph_reg    <= '0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (src_take)
        begin
            store_reg[{row_count_reg, 2'd0}] <= W'(src_data.entry_c0);
            store_reg[{row_count_reg, 2'd1}] <= W'(src_data.entry_c1);
            store_reg[{row_count_reg, 2'd2}] <= W'(src_data.entry_c2);
            store_reg[{row_count_reg, 2'd3}] <= W'(src_data.entry_c3);
            acc_reg <= '0;
        end

        if (state_reg == ST_ADJ || state_reg == ST_DET || state_reg == ST_TRN)
        begin
            case (ph_reg)
                2'd0:
                begin
                    if (state_reg == ST_TRN)
                    begin
                        opa_reg <= OP_W'(inv_reg[sub_reg[1:0]]);
                    end
                    else
                    begin
                        opa_reg <= OP_W'(rd_val);
                    end
                end
                2'd1:
                begin
                    if (state_reg == ST_DET)
                    begin
                        opb_reg <= sub_reg[0] ? adj_val[ADJ_W-1:W] : {1'b0, adj_val[W-1:0]};
                    end
                    else
                    begin
                        opb_reg <= OP_W'(rd_val);
                    end
                end
                2'd3:
                begin
                    // The determinant sum starts from zero after the last adjugate entry.
                    if (state_reg == ST_ADJ && sub_reg[0] && k_reg == 4'd8)
                    begin
                        acc_reg <= '0;
                    end
                    else
                    begin
                        acc_reg <= acc_next;
                    end
                    if (state_reg == ST_ADJ && sub_reg[0])
                    begin
                        adj_reg[k_reg] <= adj_new;
                    end
                    if (state_reg == ST_TRN && sub_reg == 3'd2)
                    begin
                        res_reg.row_index <= row_reg;
                        res_reg.inv_c0    <= FIELD_W'(inv_reg[0]);
                        res_reg.inv_c1    <= FIELD_W'(inv_reg[1]);
                        res_reg.inv_c2    <= FIELD_W'(inv_reg[2]);
                        res_reg.inv_c3    <= FIELD_W'(tr_val);
                        res_reg.status    <= 1'b0;
                        res_reg.saturated <= sat_reg | tr_over;
                        res_reg.last      <= (row_reg == 2'd2);
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (state_reg == ST_CHK)
        begin
            detneg_reg <= acc_reg[ACC_W-1];
            den_reg    <= acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : acc_reg;
            sat_reg    <= 1'b0;
            if (acc_reg == '0)
            begin
                res_reg <= '{row_index: '0, inv_c0: '0, inv_c1: '0, inv_c2: '0,
                             inv_c3: '0, status: 1'b1, saturated: 1'b0, last: 1'b1};
            end
        end

        if (state_reg == ST_OUT && res_take)
        begin
            sat_reg <= 1'b0;
        end

        if (div_ctl.start)
        begin
            qneg_reg <= adj_val[ADJ_W-1] ^ detneg_reg;
        end

        if (state_reg == ST_DIV && ph_reg == 2'd1 && div_sts.done)
        begin
            inv_reg[col_reg] <= q_val;
            sat_reg          <= sat_reg | q_over;
            if (col_reg == 2'd2)
            begin
                acc_reg <= '0;
            end
        end
    end

    assign src_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

// ===== tb/sv/affine_matrix_inverse_3x4_checker.sv =====
// Checker for the affine 3x4 inverse: watches both channels, predicts each inverse row
// from the accepted source rows and compares every result transfer. Depends on ami_pkg.
module affine_matrix_inverse_3x4_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    input  logic               src_stall,
    input  ami_pkg::src_item_t src_data,
    input  logic               res_valid,
    input  logic               res_stall,
    input  ami_pkg::res_item_t res_data,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ami_pkg::*;

    localparam int EW = ENTRY_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;

    typedef logic signed [127:0] wide_t;

    logic signed [EW-1:0] src_rows [12];
    logic [1:0]           rows_seen;
    res_item_t            inverse_rows_q [$];

    initial fail_count = 0;
    assign pending = inverse_rows_q.size();

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic wide_t cross2(input logic signed [EW-1:0] p, q, r, s);
        return wide_t'(p) * wide_t'(q) - wide_t'(r) * wide_t'(s);
    endfunction

    function automatic wide_t magnitude(input wide_t v);
        return (v < 0) ? -v : v;
    endfunction

    // Clamp a sign-magnitude value to the signed entry range.
    function automatic logic signed [EW-1:0] clamp_entry(input wide_t mag, input bit neg,
                                                          inout bit clipped);
        wide_t lim;
        lim = (wide_t'(1) <<< (EW - 1)) - 1;
        if (neg) begin
            if (mag > lim + 1) begin
                clipped = 1'b1;
                return {1'b1, {(EW-1){1'b0}}};
            end
            return -mag[EW-1:0];
        end
        if (mag > lim) begin
            clipped = 1'b1;
            return {1'b0, {(EW-1){1'b1}}};
        end
        return mag[EW-1:0];
    endfunction

    function automatic void predict_inverse();
        logic signed [EW-1:0] a [3][4];
        logic signed [EW-1:0] inv [3][4];
        wide_t     adj [3][3];
        wide_t     det, det_mag, num, t;
        bit        det_neg, clipped;
        res_item_t row;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 4; j++)
                a[i][j] = src_rows[i*4+j];
        adj[0][0] =  cross2(a[1][1], a[2][2], a[2][1], a[1][2]);
        adj[0][1] = -cross2(a[0][1], a[2][2], a[2][1], a[0][2]);
        adj[0][2] =  cross2(a[0][1], a[1][2], a[1][1], a[0][2]);
        adj[1][0] = -cross2(a[1][0], a[2][2], a[2][0], a[1][2]);
        adj[1][1] =  cross2(a[0][0], a[2][2], a[2][0], a[0][2]);
        adj[1][2] = -cross2(a[0][0], a[1][2], a[1][0], a[0][2]);
        adj[2][0] =  cross2(a[1][0], a[2][1], a[2][0], a[1][1]);
        adj[2][1] = -cross2(a[0][0], a[2][1], a[2][0], a[0][1]);
        adj[2][2] =  cross2(a[0][0], a[1][1], a[1][0], a[0][1]);
        det = wide_t'(a[0][0]) * adj[0][0] + wide_t'(a[0][1]) * adj[1][0]
            + wide_t'(a[0][2]) * adj[2][0];
        if (det == 0) begin
            row = '0;
            row.status = 1'b1;
            row.last   = 1'b1;
            inverse_rows_q.push_back(row);
            return;
        end
        det_neg = det < 0;
        det_mag = magnitude(det);
        for (int i = 0; i < 3; i++) begin
            clipped = 1'b0;
            for (int j = 0; j < 3; j++) begin
                num = adj[i][j] <<< (2 * FB);
                inv[i][j] = clamp_entry($unsigned(magnitude(num)) / $unsigned(det_mag),
                                        (num < 0) != det_neg, clipped);
            end
            t = -(wide_t'(inv[i][0]) * wide_t'(a[0][3]) + wide_t'(inv[i][1]) * wide_t'(a[1][3])
                + wide_t'(inv[i][2]) * wide_t'(a[2][3]));
            inv[i][3] = clamp_entry($unsigned(magnitude(t)) >> FB, t < 0, clipped);
            row.row_index = 2'(i);
            row.inv_c0    = inv[i][0];
            row.inv_c1    = inv[i][1];
            row.inv_c2    = inv[i][2];
            row.inv_c3    = inv[i][3];
            row.status    = 1'b0;
            row.saturated = clipped;
            row.last      = (i == 2);
            inverse_rows_q.push_back(row);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_item_t want;
        if (!rst_n)
        begin
            rows_seen <= '0;
        end
        else
        begin
            if (src_valid && !src_stall)
            begin
                src_rows[rows_seen*4+0] = src_data.entry_c0;
                src_rows[rows_seen*4+1] = src_data.entry_c1;
                src_rows[rows_seen*4+2] = src_data.entry_c2;
                src_rows[rows_seen*4+3] = src_data.entry_c3;
                if (rows_seen == 2)
                begin
                    predict_inverse();
                    rows_seen <= '0;
                end
                else
                begin
                    rows_seen <= rows_seen + 1'b1;
                end
            end
            if (res_valid && !res_stall)
            begin
                if (inverse_rows_q.size() == 0)
                begin
                    report_mismatch("unexpected result", res_data[63:0], '0);
                end
                else
                begin
                    want = inverse_rows_q.pop_front();
                    if (res_data.row_index != want.row_index)
                        report_mismatch("row_index", res_data.row_index, want.row_index);
                    if (res_data.inv_c0 != want.inv_c0)
                        report_mismatch("inv_c0", res_data.inv_c0, want.inv_c0);
                    if (res_data.inv_c1 != want.inv_c1)
                        report_mismatch("inv_c1", res_data.inv_c1, want.inv_c1);
                    if (res_data.inv_c2 != want.inv_c2)
                        report_mismatch("inv_c2", res_data.inv_c2, want.inv_c2);
                    if (res_data.inv_c3 != want.inv_c3)
                        report_mismatch("inv_c3", res_data.inv_c3, want.inv_c3);
                    if (res_data.status != want.status)
                        report_mismatch("status", res_data.status, want.status);
                    if (res_data.saturated != want.saturated)
                        report_mismatch("saturated", res_data.saturated, want.saturated);
                    if (res_data.last != want.last)
                        report_mismatch("last", res_data.last, want.last);
                end
            end
        end
    end

endmodule

// ===== tb/sv/affine_matrix_inverse_3x4_tb.sv =====
// Top of the affine 3x4 inverse testbench: clock, reset, source rows and result stalls.
// Depends on ami_pkg, affine_matrix_inverse_3x4 and affine_matrix_inverse_3x4_checker.
module affine_matrix_inverse_3x4_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ami_pkg::*;

    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] PMAX = 32'h7fff_ffff;
    localparam logic [31:0] NMIN = 32'h8000_0000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      src_valid = 1'b0;
    logic      src_stall;
    src_item_t src_data = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_item_t res_data;
    int        fail_count;
    int        pending;
    int        rows_sent = 0;
    bit        stimulus_done = 1'b0;

    affine_matrix_inverse_3x4 u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    affine_matrix_inverse_3x4_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_data   (src_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // One source row; valid stays high across back-to-back transfers.
    task automatic send_row(input logic [31:0] c0, c1, c2, c3);
        int gap;
        src_valid <= 1'b1;
        src_data  <= '{entry_c0: c0, entry_c1: c1, entry_c2: c2, entry_c3: c3};
        @(posedge clk);
        while (src_stall) @(posedge clk);
        rows_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_matrix(input logic [31:0] m [12]);
        for (int i = 0; i < 3; i++)
            send_row(m[i*4], m[i*4+1], m[i*4+2], m[i*4+3]);
    endtask

    function automatic logic [31:0] extreme_value();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return PMAX;
            2:       return NMIN;
            3:       return 32'd1;
            4:       return 32'hffff_ffff;
            5:       return ONE;
            default: return -ONE;
        endcase
    endfunction

    task automatic send_random_matrix();
        logic [31:0] m [12];
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 12; i++)
        begin
            case (kind)
                6:       m[i] = $urandom();
                8:       m[i] = extreme_value();
                9:       m[i] = $urandom_range(0, 64) - 32;
                default: m[i] = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            endcase
            if (i % 4 == 3 && kind != 9) m[i] = $urandom();
        end
        // Well-formed singular case: the third row repeats the linear part of the first.
        if (kind == 7)
            for (int j = 0; j < 3; j++) m[8+j] = m[j];
        send_matrix(m);
    endtask

    initial
    begin
        int burst;
        bit hold;
        @(posedge rst_n);
        forever
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin hold = 1'b0; burst = $urandom_range(20, 200); end
                3:       begin hold = 1'b1; burst = $urandom_range(10, 40); end
                default: begin hold = 1'($urandom_range(0, 1)); burst = $urandom_range(1, 3); end
            endcase
            res_stall <= hold;
            repeat (burst) @(posedge clk);
            if (stimulus_done && pending == 0) res_stall <= 1'b0;
        end
    end

    initial
    begin
        logic [31:0] m [12];
        int wait_cycles;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity with a mixed translation.
        m = '{ONE, 0, 0, ONE + 32'h8000, 0, ONE, 0, -(2 * ONE), 0, 0, ONE, 3 * ONE};
        send_matrix(m);
        // Scaled diagonal with extreme translations.
        m = '{2 * ONE, 0, 0, PMAX, 0, ONE >> 1, 0, NMIN, 0, 0, -(4 * ONE), 0};
        send_matrix(m);
        // All zero, all maximum and all minimum are singular.
        m = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_matrix(m);
        m = '{PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX};
        send_matrix(m);
        m = '{NMIN, NMIN, NMIN, NMIN, NMIN, NMIN, NMIN, NMIN, NMIN, NMIN, NMIN, NMIN};
        send_matrix(m);
        // Tiny diagonal: the quotients overflow and clamp.
        m = '{1, 0, 0, 1, 0, 1, 0, NMIN, 0, 0, -1, PMAX};
        send_matrix(m);
        // Quarter-turn rotation.
        m = '{0, ONE, 0, NMIN, -ONE, 0, 0, ONE, 0, 0, ONE, -ONE};
        send_matrix(m);
        // Huge diagonal: tiny inverse entries.
        m = '{PMAX, 0, 0, PMAX, 0, NMIN, 0, PMAX, 0, 0, PMAX, NMIN};
        send_matrix(m);

        // Hold off until the block has drained every expected row.
        src_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);

        while (rows_sent < 370) send_random_matrix();
        src_valid <= 1'b0;
        stimulus_done = 1'b1;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        wait_cycles = 50;
        repeat (wait_cycles) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
